/* rtl/hafr_pkg.sv */
`timescale 1ns / 1ps

package hafr_pkg;

   // Framing octets
   localparam logic [7:0] FLAG_OCTET = 8'h7E;
   localparam logic [7:0] ESC_OCTET  = 8'h7D;
   localparam logic [7:0] XOR_BIT5   = 8'h20;

   // Field widths
   localparam int unsigned LEN_WIDTH   = 10;
   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned EVENT_WIDTH = 3;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 10;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_FRAME_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_FRAME_LENGTH = 1'd1;

   // Register reset values
   localparam logic [LEN_WIDTH-1:0] MIN_FRAME_LENGTH_RESET = 10'd6;
   localparam logic [LEN_WIDTH-1:0] MAX_FRAME_LENGTH_RESET = 10'd130;

   // Event codes
   localparam logic [EVENT_WIDTH-1:0] EV_ESCAPE   = 3'd0;
   localparam logic [EVENT_WIDTH-1:0] EV_STORED   = 3'd1;
   localparam logic [EVENT_WIDTH-1:0] EV_COMPLETE = 3'd2;
   localparam logic [EVENT_WIDTH-1:0] EV_RESYNC   = 3'd3;
   localparam logic [EVENT_WIDTH-1:0] EV_DISCARD  = 3'd4;
   localparam logic [EVENT_WIDTH-1:0] EV_DROP     = 3'd5;
   localparam logic [EVENT_WIDTH-1:0] EV_FULL     = 3'd6;
   localparam logic [EVENT_WIDTH-1:0] EV_CANCEL   = 3'd7;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] rx_byte;
      logic                  store_full;
   } req_payload_type;

   typedef struct packed {
      logic [EVENT_WIDTH-1:0] event_res;
      logic [BYTE_WIDTH-1:0]  byte_out;
      logic                   byte_valid;
      logic [LEN_WIDTH-1:0]   frame_bytes;
   } rsp_payload_type;

endpackage

/* rtl/hdlc_async_frame_receiver_unit.sv */
`timescale 1ns / 1ps

// HDLC asynchronous receive deframer.
// Request channel (req_valid / req_stall / req_payload): one raw serial
// octet per beat, with the downstream store_full status of that moment.
// Response channel (rsp_valid / rsp_stall / rsp_payload): exactly one beat
// per request beat, in order, carrying the event code, the unstuffed byte
// and its push strobe, and the frame length before the octet.
// Control port (csr_valid / csr_ready / csr_index / csr_data): writes the
// minimum and maximum frame length; always ready, and meant to be used
// while no octet is in flight.
// A request beat passes the input register, then the deframing logic that
// updates the escape, overflow and length state and loads the output
// register. Throughput is one octet per cycle while rsp_stall is low. A
// stalled response holds the output register; an empty input register
// still takes one more beat, then holds, and req_stall rises until the
// response moves.
// Reset clears the escape and overflow flags, the length count, both
// pipeline valid bits, and loads the length registers with 6 and 130.
module hdlc_async_frame_receiver_unit
   import hafr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic                  in_valid_ff;
   req_payload_type       in_data_ff;
   logic                  out_valid_ff;
   rsp_payload_type       out_data_ff;
   logic [LEN_WIDTH-1:0]  min_len_ff;
   logic [LEN_WIDTH-1:0]  max_len_ff;
   logic                  escape_ff;
   logic                  overflowed_ff;
   logic [LEN_WIDTH-1:0]  count_ff;

   logic                  escape_in;
   logic                  overflowed_in;
   logic [LEN_WIDTH-1:0]  count_in;
   rsp_payload_type       out_data_in;
   logic                  advance;
   logic                  req_take;
   logic [BYTE_WIDTH-1:0] data_byte;

   // Move the stage forward whenever the output register is free or drains
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // Unstuff the byte when an escape is pending
   assign data_byte = in_data_ff.rx_byte ^ (escape_ff ? XOR_BIT5 : '0);

   // Deframing decision for the registered octet
   always_comb begin
      escape_in     = escape_ff;
      overflowed_in = overflowed_ff;
      count_in      = count_ff;
      out_data_in.event_res   = EV_ESCAPE;
      out_data_in.byte_out    = '0;
      out_data_in.byte_valid  = 1'b0;
      out_data_in.frame_bytes = count_ff;

      if (in_data_ff.rx_byte == FLAG_OCTET) begin
         if (escape_ff) begin
            escape_in = 1'b0;
            out_data_in.event_res = EV_CANCEL;
         end else if (overflowed_ff) begin
            overflowed_in = 1'b0;
            count_in      = '0;
            out_data_in.event_res = EV_DISCARD;
         end else if (count_ff >= min_len_ff) begin
            count_in = '0;
            out_data_in.event_res = EV_COMPLETE;
         end else begin
            count_in = '0;
            out_data_in.event_res = EV_RESYNC;
         end
      end else if (!escape_ff && in_data_ff.rx_byte == ESC_OCTET) begin
         escape_in = 1'b1;
         out_data_in.event_res = EV_ESCAPE;
      end else begin
         escape_in = 1'b0;
         if (count_ff < max_len_ff) begin
            if (in_data_ff.store_full) begin
               out_data_in.event_res = EV_FULL;
            end else begin
               count_in = count_ff + LEN_WIDTH'(1);
               out_data_in.event_res  = EV_STORED;
               out_data_in.byte_out   = data_byte;
               out_data_in.byte_valid = 1'b1;
            end
         end else begin
            overflowed_in = 1'b1;
            out_data_in.event_res = EV_DROP;
         end
      end
   end

   // Control state: pipeline valid bits, deframer flags, length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         escape_ff     <= 1'b0;
         overflowed_ff <= 1'b0;
         count_ff      <= '0;
         min_len_ff    <= MIN_FRAME_LENGTH_RESET;
         max_len_ff    <= MAX_FRAME_LENGTH_RESET;
      end else begin
         // Fill the input register whenever it is not held
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               escape_ff     <= escape_in;
               overflowed_ff <= overflowed_in;
               count_ff      <= count_in;
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MIN_FRAME_LENGTH) begin
               min_len_ff <= csr_data;
            end else begin
               max_len_ff <= csr_data;
            end
         end
      end
   end

   // Payload registers: load on each advancing beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_payload;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   // The push strobe marks exactly the stored-byte event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.byte_valid == (rsp_payload.event_res == EV_STORED)))
      else $error("byte_valid does not match stored event");

   // A stored byte grows the frame length by one
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && out_data_in.event_res == EV_STORED)
      |=> count_ff == $past(count_ff) + LEN_WIDTH'(1))
      else $error("frame length did not advance on stored byte");

   // An absorbed escape leaves the escape armed
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && out_data_in.event_res == EV_ESCAPE) |=> escape_ff)
      else $error("escape not armed");

   // A dropped byte marks the frame overflowed
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && out_data_in.event_res == EV_DROP) |=> overflowed_ff)
      else $error("overflow not flagged on dropped byte");

   // Closing flags restart the length count
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && (out_data_in.event_res == EV_COMPLETE
         || out_data_in.event_res == EV_RESYNC || out_data_in.event_res == EV_DISCARD))
      |=> count_ff == '0)
      else $error("frame length not cleared at flag");

endmodule

/* test/tb_hdlc_async_frame_receiver_unit.sv */
`timescale 1ns / 1ps

module tb_hdlc_async_frame_receiver_unit
   import hafr_pkg::*;
();

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned PHASE_OCTETS   = 300;
   localparam int unsigned MAX_PRINTED    = 200;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_payload_type            req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_payload_type            rsp_payload;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // Deframer shadow state and length registers
   logic                 esc_armed = 1'b0;
   logic                 frame_over = 1'b0;
   logic [LEN_WIDTH-1:0] frame_len = '0;
   logic [LEN_WIDTH-1:0] cfg_min_len = MIN_FRAME_LENGTH_RESET;
   logic [LEN_WIDTH-1:0] cfg_max_len = MAX_FRAME_LENGTH_RESET;

   rsp_payload_type pending_events[$];
   rsp_payload_type want_event;
   int unsigned     octets_sent = 0;
   int unsigned     beats_checked = 0;
   int unsigned     error_count = 0;
   int unsigned     idle_cycles = 0;
   int unsigned     sender_idle_pct = 0;
   int unsigned     stall_pct = 0;

   hdlc_async_frame_receiver_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predict the event for one octet and advance the shadow state
   function automatic rsp_payload_type deframe_octet(input req_payload_type item);
      rsp_payload_type r;
      logic [BYTE_WIDTH-1:0] b;
      b = item.rx_byte;
      r = '0;
      r.frame_bytes = frame_len;
      if (b == FLAG_OCTET) begin
         if (esc_armed) begin
            // flag inside an escape only clears the escape
            esc_armed = 1'b0;
            r.event_res = EV_CANCEL;
         end else if (frame_over) begin
            frame_over = 1'b0;
            frame_len = '0;
            r.event_res = EV_DISCARD;
         end else if (frame_len >= cfg_min_len) begin
            frame_len = '0;
            r.event_res = EV_COMPLETE;
         end else begin
            frame_len = '0;
            r.event_res = EV_RESYNC;
         end
      end else if (!esc_armed && b == ESC_OCTET) begin
         esc_armed = 1'b1;
         r.event_res = EV_ESCAPE;
      end else begin
         if (esc_armed) begin
            esc_armed = 1'b0;
            b = b ^ XOR_BIT5;
         end
         // length limit wins over store full
         if (frame_len < cfg_max_len) begin
            if (item.store_full) begin
               r.event_res = EV_FULL;
            end else begin
               frame_len = frame_len + 1'b1;
               r.byte_out = b;
               r.byte_valid = 1'b1;
               r.event_res = EV_STORED;
            end
         end else begin
            frame_over = 1'b1;
            r.event_res = EV_DROP;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (error_count < MAX_PRINTED)
         $display("%0t: beat %0d %s: got %0h want %0h", $realtime, beats_checked, what,
                  got, want);
      error_count++;
   endtask

   // Send one raw octet; valid stays high after the beat for back-to-back use
   task automatic send_octet(input logic [BYTE_WIDTH-1:0] b, input logic full);
      req_payload_type item;
      item.rx_byte = b;
      item.store_full = full;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_events.push_back(deframe_octet(item));
      octets_sent++;
   endtask

   // Hold the sender until every expected beat has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   task automatic write_length_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                   input logic [LEN_WIDTH-1:0] val);
      drain_results();
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_MIN_FRAME_LENGTH)
         cfg_min_len = val;
      else
         cfg_max_len = val;
   endtask

   task automatic set_idling(input int unsigned mode);
      case (mode % 4)
         0: begin sender_idle_pct = 0;  stall_pct = 0;  end
         1: begin sender_idle_pct = 60; stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  stall_pct = 60; end
         default: begin sender_idle_pct = 12; stall_pct = 12; end
      endcase
   endtask

   // Stuff a data byte the way a transmitter would
   task automatic send_data_byte(input logic [BYTE_WIDTH-1:0] b, input logic full);
      if (b == FLAG_OCTET || b == ESC_OCTET) begin
         send_octet(ESC_OCTET, 1'($urandom_range(0, 1)));
         send_octet(b ^ XOR_BIT5, full);
      end else begin
         send_octet(b, full);
      end
   endtask

   function automatic logic [BYTE_WIDTH-1:0] pick_data_byte();
      case ($urandom_range(0, 9))
         0: return FLAG_OCTET;
         1: return ESC_OCTET;
         2: return FLAG_OCTET ^ XOR_BIT5;
         3: return ESC_OCTET ^ XOR_BIT5;
         default: return BYTE_WIDTH'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] pick_noise_byte();
      case ($urandom_range(0, 5))
         0, 1: return FLAG_OCTET;
         2, 3: return ESC_OCTET;
         default: return BYTE_WIDTH'($urandom_range(0, 255));
      endcase
   endfunction

   // One well-formed frame (mostly) or a short burst of line noise
   task automatic send_random_burst();
      int unsigned top;
      int unsigned len;
      int unsigned n;
      if ($urandom_range(0, 99) < 80) begin
         top = cfg_max_len + 3;
         if (top > 48) top = 48;
         len = $urandom_range(0, top);
         if ($urandom_range(0, 3) == 0 && cfg_min_len < 40)
            len = cfg_min_len + $urandom_range(0, 2) - ((cfg_min_len > 0) ? 1 : 0);
         for (int i = 0; i < len; i++)
            send_data_byte(pick_data_byte(), $urandom_range(0, 99) < 8);
         send_octet(FLAG_OCTET, 1'($urandom_range(0, 1)));
      end else begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++)
            send_octet(pick_noise_byte(), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_stuffing_basics();
      set_idling(0);
      send_octet(FLAG_OCTET, 1'b0);                // empty frame resyncs
      send_octet(8'h00, 1'b0);
      send_octet(8'hFF, 1'b0);
      send_octet(ESC_OCTET, 1'b0);
      send_octet(8'h5E, 1'b0);                     // unstuffs to a flag value
      send_octet(ESC_OCTET, 1'b1);
      send_octet(8'h5D, 1'b0);
      send_octet(ESC_OCTET, 1'b0);
      send_octet(ESC_OCTET, 1'b0);                 // second escape is data
      send_octet(ESC_OCTET, 1'b0);
      send_octet(FLAG_OCTET, 1'b0);                // flag cancels the escape
      send_octet(8'h11, 1'b1);                     // store full rejects
      send_octet(ESC_OCTET, 1'b0);
      send_octet(8'h33, 1'b1);                     // escape consumed by the reject
      send_octet(8'h44, 1'b0);
      send_octet(FLAG_OCTET, 1'b0);                // minimum length reached
   endtask

   task automatic test_length_limits();
      set_idling(3);
      write_length_reg(CSR_MIN_FRAME_LENGTH, 10'd0);
      write_length_reg(CSR_MAX_FRAME_LENGTH, 10'd2);
      send_octet(FLAG_OCTET, 1'b0);                // empty frame completes
      send_octet(8'h12, 1'b0);
      send_octet(8'h34, 1'b0);
      send_octet(8'h56, 1'b0);                     // at the limit: dropped
      send_octet(8'h78, 1'b1);                     // dropped even when full
      send_octet(FLAG_OCTET, 1'b0);                // overflowed frame discarded
      write_length_reg(CSR_MAX_FRAME_LENGTH, 10'd0);
      send_octet(8'h9A, 1'b0);
      send_octet(FLAG_OCTET, 1'b0);
      // raise the limit mid-frame; storing resumes, overflow stays set
      write_length_reg(CSR_MAX_FRAME_LENGTH, 10'd1);
      send_octet(8'hBC, 1'b0);
      send_octet(8'hDE, 1'b0);
      write_length_reg(CSR_MAX_FRAME_LENGTH, 10'd3);
      send_octet(8'hF0, 1'b0);
      send_octet(FLAG_OCTET, 1'b0);
   endtask

   task automatic test_random_traffic();
      logic [LEN_WIDTH-1:0] min_set[6] = '{10'd6, 10'd0, 10'd1023, 10'd3, 10'd0, 10'd12};
      logic [LEN_WIDTH-1:0] max_set[6] = '{10'd130, 10'd0, 10'd1023, 10'd8, 10'd1, 10'd20};
      int unsigned start;
      for (int p = 0; p < 6; p++) begin
         write_length_reg(CSR_MIN_FRAME_LENGTH, min_set[p]);
         write_length_reg(CSR_MAX_FRAME_LENGTH, max_set[p]);
         set_idling(p);
         start = octets_sent;
         // one long frame pushes the length count past 511, into bit 9
         if (max_set[p] == 10'd1023) begin
            for (int i = 0; i < 520; i++)
               send_data_byte(BYTE_WIDTH'($urandom_range(0, 255)), 1'b0);
            send_octet(FLAG_OCTET, 1'b0);
         end
         while (octets_sent - start < PHASE_OCTETS) begin
            send_random_burst();
            if ($urandom_range(0, 29) == 0) drain_results();
         end
      end
   endtask

   // Receiver stall pattern
   always @(posedge clock)
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

   // Compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_payload), 32'd0);
         end else begin
            want_event = pending_events.pop_front();
            if (rsp_payload.event_res !== want_event.event_res)
               report_mismatch("event_res", 32'(rsp_payload.event_res),
                               32'(want_event.event_res));
            if (rsp_payload.byte_out !== want_event.byte_out)
               report_mismatch("byte_out", 32'(rsp_payload.byte_out),
                               32'(want_event.byte_out));
            if (rsp_payload.byte_valid !== want_event.byte_valid)
               report_mismatch("byte_valid", 32'(rsp_payload.byte_valid),
                               32'(want_event.byte_valid));
            if (rsp_payload.frame_bytes !== want_event.frame_bytes)
               report_mismatch("frame_bytes", 32'(rsp_payload.frame_bytes),
                               32'(want_event.frame_bytes));
         end
         beats_checked++;
      end
   end

   // Abort when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_hdlc_async_frame_receiver_unit: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_stuffing_basics();
      test_length_limits();
      test_random_traffic();
      drain_results();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("tb_hdlc_async_frame_receiver_unit: done, clean");
      else
         $display("tb_hdlc_async_frame_receiver_unit: done, errors");
      $finish;
   end

endmodule
